@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file iprl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/core/iprl_pkg.sv @@
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared types and constants for the address range access list.
// ----------------------------------------------------------------------------
package iprl_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int TOTAL_W = 7;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_DEF,
        ST_PUSH,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

    // Classified command handed from front to back.
    typedef struct packed {
        cmd_t         cmd;
        logic [127:0] lo_b;   // range start, or query address for check
        logic [127:0] hi_b;   // range end
        logic [7:0]   action;
    } job_t;

    typedef struct packed {
        logic [7:0]         decision;
        logic               found;
        logic               full;
        logic [TOTAL_W-1:0] total;
    } res_t;
endpackage

@@ rtl/core/iprl_front.sv @@
// ----------------------------------------------------------------------------
// iprl_front
// Accepts commands, builds network ranges and queues jobs (two deep).
// ----------------------------------------------------------------------------
module iprl_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic              s_is_v6,
    input  logic [63:0]       s_addr_hi,
    input  logic [63:0]       s_addr_lo,
    input  logic [7:0]        s_prefix_len,
    input  logic [7:0]        s_action_code,
    output logic              job_valid,
    input  logic              job_ready,
    output iprl_pkg::job_t    job
);
    import iprl_pkg::*;

    job_t         q_reg [2];
    logic [1:0]   cnt_reg;
    logic         rd_reg;
    logic [127:0] addr;
    logic [127:0] host_mask;
    logic [7:0]   plen;
    logic [7:0]   host;
    job_t         nj;
    logic         push_in, pop;

    always_comb begin
        addr = s_is_v6 ? {s_addr_hi, s_addr_lo} : {96'd0, s_addr_lo[31:0]};
        if (s_is_v6) begin
            plen = (s_prefix_len > 8'd128) ? 8'd128 : s_prefix_len;
            host = 8'd128 - plen;
        end else begin
            plen = (s_prefix_len > 8'd32) ? 8'd32 : s_prefix_len;
            host = 8'd32 - plen;
        end
        host_mask = (host[7]) ? {128{1'b1}} : ~({128{1'b1}} << host[6:0]);
        nj.cmd = cmd_t'(s_cmd);
        nj.action = s_action_code;
        if (s_cmd == CMD_CHECK) begin
            nj.lo_b = addr;
            nj.hi_b = addr;
        end else begin
            nj.lo_b = addr & ~host_mask;
            nj.hi_b = (addr & ~host_mask) | host_mask;
        end
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];
    assign push_in   = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push_in} - {1'b0, pop};
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
        if (push_in) begin
            q_reg[rd_reg ^ (cnt_reg == 2'd1)] <= nj;
        end
    end
endmodule

@@ rtl/core/iprl_back.sv @@
// ----------------------------------------------------------------------------
// iprl_back
// Runs jobs against the range table: append, compacting delete, newest-first
// scan. Table lives in one memory, read with one registered port.
// ----------------------------------------------------------------------------
module iprl_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  iprl_pkg::job_t  job,
    output logic            res_valid,
    input  logic            res_ready,
    output iprl_pkg::res_t  res
);
    import iprl_pkg::*;

    localparam int EW = 128 + 128 + 8;

    logic [EW-1:0] mem [ENTRIES];
    logic [EW-1:0] rdata_reg;

    state_t     state_reg, state_next;
    job_t       job_reg, job_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;   // read index / remaining for check
    logic [CNT_W-1:0] w_reg, w_next;
    logic       def_reg, def_next;
    res_t       res_reg, res_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [EW-1:0]    wdata;
    logic             re;

    logic [127:0] e_lo, e_hi;
    logic [7:0]   e_act;
    logic         hit_del, hit_chk;

    assign e_lo  = rdata_reg[EW-1 -: 128];
    assign e_hi  = rdata_reg[135:8];
    assign e_act = rdata_reg[7:0];
    assign hit_del = (e_lo == job_reg.lo_b) && (job_reg.hi_b <= e_hi);
    assign hit_chk = (e_lo <= job_reg.lo_b) && (job_reg.lo_b <= e_hi);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            def_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            def_reg   <= def_next;
        end
        job_reg <= job_next;
        i_reg   <= i_next;
        w_reg   <= w_next;
        res_reg <= res_next;
    end

    assign job_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res = res_reg;

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        count_next = count_reg;
        i_next     = i_reg;
        w_next     = w_reg;
        def_next   = def_reg;
        res_next   = res_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        re = 1'b0;
        raddr = '0;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_next = job;
                    res_next = '0;
                    case (job.cmd)
                        CMD_PUSH: begin
                            state_next = def_reg ? ST_PUSH : ST_PUSH_DEF;
                        end
                        CMD_DELETE: begin
                            i_next = '0;
                            w_next = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_CHECK: begin
                            if (count_reg == '0) begin
                                res_next.decision = 8'd1;
                                res_next.total = TOTAL_W'(count_reg);
                                state_next = ST_DONE;
                            end else begin
                                i_next = count_reg;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            res_next.total = TOTAL_W'(count_reg);
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUSH_DEF: begin
                we = 1'b1;
                waddr = '0;
                wdata = {128'd0, 128'hFFFF_FFFF, (job_reg.action == 8'd0) ? 8'd1 : 8'd0};
                count_next = CNT_W'(1);
                def_next = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (count_reg >= CNT_W'(ENTRIES)) begin
                    res_next.full = 1'b1;
                    res_next.total = TOTAL_W'(count_reg);
                end else begin
                    we = 1'b1;
                    waddr = count_reg[IDX_W-1:0];
                    wdata = {job_reg.lo_b, job_reg.hi_b, job_reg.action};
                    count_next = count_reg + CNT_W'(1);
                    res_next.total = TOTAL_W'(count_reg + CNT_W'(1));
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // issue one read, then evaluate it in ST_WAIT
                if (job_reg.cmd == CMD_DELETE) begin
                    if (i_reg == count_reg) begin
                        count_next = w_reg;
                        res_next.total = TOTAL_W'(w_reg);
                        state_next = ST_DONE;
                    end else begin
                        re = 1'b1;
                        raddr = i_reg[IDX_W-1:0];
                        state_next = ST_WAIT;
                    end
                end else begin
                    if (i_reg == '0) begin
                        res_next.total = TOTAL_W'(count_reg);
                        state_next = ST_DONE;
                    end else begin
                        re = 1'b1;
                        raddr = IDX_W'(i_reg - CNT_W'(1));
                        i_next = i_reg - CNT_W'(1);
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (job_reg.cmd == CMD_DELETE) begin
                    if (!hit_del) begin
                        if (w_reg != i_reg) begin
                            we = 1'b1;
                            waddr = w_reg[IDX_W-1:0];
                            wdata = rdata_reg;
                        end
                        w_next = w_reg + CNT_W'(1);
                    end
                    i_next = i_reg + CNT_W'(1);
                    state_next = ST_SCAN;
                end else begin
                    if (hit_chk) begin
                        res_next.decision = e_act;
                        res_next.found = 1'b1;
                        res_next.total = TOTAL_W'(count_reg);
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/core/ip_range_access_list.sv @@
// The first push writes the default entry before the new one; an unused command or
// a check on an empty table answers without reading the table; a check reads entries newest
// first until a hit, and a delete or missed check reads every stored entry through the read port.
// Throughput: one transaction at a time in the back end; a two-entry job
// queue lets the input side take two more commands while one runs.
// Reset (aresetn low, synchronous) clears the entry count and queue, not the memory.
module ip_range_access_list (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_is_v6,
    input  logic [63:0] s_addr_hi,
    input  logic [63:0] s_addr_lo,
    input  logic [7:0]  s_prefix_len,
    input  logic [7:0]  s_action_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_decision,
    output logic        m_found,
    output logic        m_table_full,
    output logic [6:0]  m_entry_total
);
    import iprl_pkg::*;

    logic job_valid, job_ready;
    job_t job;
    res_t res;

    // Front: mask address to prefix and queue the transaction.
    iprl_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_is_v6, .s_addr_hi,
        .s_addr_lo, .s_prefix_len, .s_action_code,
        .job_valid, .job_ready, .job
    );

    // Back: run the transaction on the table and hold the result.
    iprl_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .res_valid(m_valid), .res_ready(m_ready), .res
    );

    assign m_decision    = res.decision;
    assign m_found       = res.found;
    assign m_table_full  = res.full;
    assign m_entry_total = res.total;
endmodule

@@ rtl/core/iprl_checker.sv @@
// ----------------------------------------------------------------------------
// iprl_checker
// Port-level checks on the access list results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module iprl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_decision,
    input logic       m_found,
    input logic       m_table_full,
    input logic [6:0] m_entry_total
);
    `ASSERT_IMPL(a_total_range, aclk, aresetn, m_valid, m_entry_total <= 7'd64)
    `ASSERT_IMPL(a_full_nofound, aclk, aresetn, m_valid && m_table_full, !m_found)
    `ASSERT_IMPL(a_full_max, aclk, aresetn, m_valid && m_table_full, m_entry_total == 7'd64)
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_decision))
    `ASSERT_IMPL(a_empty_one, aclk, aresetn, m_valid && m_found, m_entry_total != 7'd0)
endmodule

bind ip_range_access_list iprl_checker u_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_decision, .m_found,
    .m_table_full, .m_entry_total
);

@@ bench/ip_range_access_list_tb.sv @@
// ----------------------------------------------------------------------------
// ip_range_access_list_tb
// Drives push, delete and check transactions into the range access list,
// predicts each response from a behavioral copy of the range table, and
// compares every response field by field under varied handshake pressure.
// ----------------------------------------------------------------------------
module ip_range_access_list_tb;
    import iprl_pkg::*;

    localparam int PERIOD      = 12;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 20;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic        s_is_v6;
    logic [63:0] s_addr_hi;
    logic [63:0] s_addr_lo;
    logic [7:0]  s_prefix_len;
    logic [7:0]  s_action_code;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_decision;
    logic        m_found;
    logic        m_table_full;
    logic [6:0]  m_entry_total;

    ip_range_access_list i_dut (.*);

    // Clock: high then low, one period.
    always begin
        aclk = 1'b1;
        #(PERIOD / 2);
        aclk = 1'b0;
        #(PERIOD / 2);
    end

    // Behavioral copy of the range table.
    logic [127:0] tbl_start [ENTRIES];
    logic [127:0] tbl_end   [ENTRIES];
    logic [7:0]   tbl_act   [ENTRIES];
    int unsigned  tbl_count;
    bit           default_done;

    res_t expected_responses [$];

    int  mismatch_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  cycle_count = 0;

    // Network bounds of an address and prefix; IPv4 lives in the low 32 bits.
    task automatic network_bounds(input bit v6, input logic [127:0] addr,
                                  input int unsigned plen,
                                  output logic [127:0] lo, output logic [127:0] hi);
        int unsigned  width;
        logic [127:0] host_mask;
        width = v6 ? 128 : 32;
        if (!v6) addr = {96'd0, addr[31:0]};
        if (plen > width) plen = width;
        if (width - plen == 128) host_mask = '1;
        else host_mask = (128'd1 << (width - plen)) - 128'd1;
        lo = addr & ~host_mask;
        hi = lo | host_mask;
    endtask

    // Apply one accepted command to the table copy and queue its response.
    task automatic predict_response(input logic [1:0] cmd, input bit v6,
                                    input logic [63:0] ahi, input logic [63:0] alo,
                                    input logic [7:0] plen, input logic [7:0] act);
        res_t         r;
        logic [127:0] lo, hi, q;
        int unsigned  w;
        r = '0;
        case (cmd)
            CMD_PUSH: begin
                if (!default_done) begin
                    tbl_start[0] = '0;
                    tbl_end[0]   = 128'hFFFF_FFFF;
                    tbl_act[0]   = (act == 8'd0) ? 8'd1 : 8'd0;
                    tbl_count    = 1;
                    default_done = 1'b1;
                end
                if (tbl_count >= ENTRIES) begin
                    r.full = 1'b1;
                end else begin
                    network_bounds(v6, {ahi, alo}, {24'd0, plen}, lo, hi);
                    tbl_start[tbl_count] = lo;
                    tbl_end[tbl_count]   = hi;
                    tbl_act[tbl_count]   = act;
                    tbl_count++;
                end
            end
            CMD_DELETE: begin
                network_bounds(v6, {ahi, alo}, {24'd0, plen}, lo, hi);
                w = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (!(tbl_start[i] == lo && hi <= tbl_end[i])) begin
                        tbl_start[w] = tbl_start[i];
                        tbl_end[w]   = tbl_end[i];
                        tbl_act[w]   = tbl_act[i];
                        w++;
                    end
                end
                tbl_count = w;
            end
            CMD_CHECK: begin
                if (tbl_count == 0) begin
                    r.decision = 8'd1;
                end else begin
                    q = v6 ? {ahi, alo} : {96'd0, alo[31:0]};
                    for (int i = tbl_count - 1; i >= 0; i--) begin
                        if (tbl_start[i] <= q && q <= tbl_end[i]) begin
                            r.decision = tbl_act[i];
                            r.found    = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.total = tbl_count[TOTAL_W-1:0];
        expected_responses.push_back(r);
    endtask

    // Offer one transaction at the falling edge and hold it until accepted.
    task automatic send_command(input logic [1:0] cmd, input bit v6,
                                input logic [63:0] ahi, input logic [63:0] alo,
                                input logic [7:0] plen, input logic [7:0] act);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_is_v6       <= v6;
        s_addr_hi     <= ahi;
        s_addr_lo     <= alo;
        s_prefix_len  <= plen;
        s_action_code <= act;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_response(cmd, v6, ahi, alo, plen, act);
        @(negedge aclk);
    endtask

    // Random 64-bit word, sometimes at an extreme.
    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Drop valid and wait until every response is back.
    task automatic drain_responses();
        s_valid <= 1'b0;
        while (expected_responses.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted response with the oldest prediction.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response: dec=%0d found=%0d full=%0d total=%0d",
                             m_decision, m_found, m_table_full, m_entry_total);
            end else begin
                want = expected_responses.pop_front();
                if (m_decision !== want.decision || m_found !== want.found ||
                    m_table_full !== want.full || m_entry_total !== want.total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp dec=%0d found=%0d full=%0d total=%0d %s",
                                 want.decision, want.found, want.full, want.total,
                                 $sformatf("got dec=%0d found=%0d full=%0d total=%0d",
                                           m_decision, m_found, m_table_full,
                                           m_entry_total));
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Empty table, first push with default entry, extremes and unused command.
    task automatic test_directed();
        send_command(CMD_CHECK, 1'b0, '0, '0, 8'd0, 8'd0);
        send_command(CMD_CHECK, 1'b1, '1, '1, 8'd0, 8'd0);
        send_command(CMD_NONE, 1'b1, '1, '1, 8'hFF, 8'hFF);
        send_command(CMD_PUSH, 1'b0, '1, 64'hC0A8_0101, 8'd24, 8'd0);
        send_command(CMD_CHECK, 1'b0, '0, 64'h0A00_0001, 8'd0, 8'd0);
        send_command(CMD_CHECK, 1'b0, '1, 64'hFFFF_FFFF_C0A8_01FE, 8'd0, 8'd0);
        // Prefix too long is clamped.
        send_command(CMD_PUSH, 1'b0, '0, '1, 8'd200, 8'hFF);
        send_command(CMD_PUSH, 1'b1, '1, '1, 8'd255, 8'h5A);
        // IPv6 whole space.
        send_command(CMD_PUSH, 1'b1, 64'h1234, 64'h5678, 8'd0, 8'hA5);
        send_command(CMD_CHECK, 1'b1, '1, '1, 8'd0, 8'd0);
        send_command(CMD_CHECK, 1'b1, '0, '0, 8'd0, 8'd0);
        send_command(CMD_PUSH, 1'b1, 64'h2001_0DB8_0000_0000, '0, 8'd64, 8'h33);
        send_command(CMD_CHECK, 1'b1, 64'h2001_0DB8_0000_0000, '1, 8'd0, 8'd0);
        send_command(CMD_DELETE, 1'b1, '0, '0, 8'd0, 8'd0);
        send_command(CMD_DELETE, 1'b0, '0, '0, 8'd0, 8'd0);
        send_command(CMD_CHECK, 1'b0, '0, 64'd5, 8'd0, 8'd0);
        send_command(CMD_DELETE, 1'b1, '1, '1, 8'd128, 8'd0);
        send_command(CMD_DELETE, 1'b0, '0, '1, 8'd32, 8'd0);
        send_command(CMD_CHECK, 1'b0, '0, '0, 8'd0, 8'd0);
        drain_responses();
    endtask

    // Fill past capacity so pushes are flagged, then delete the whole-space IPv4 range.
    task automatic test_full_table();
        for (int i = 0; i < ENTRIES + 3; i++)
            send_command(CMD_PUSH, 1'b0, '0, {32'd0, $urandom}, 8'd32, i[7:0]);
        send_command(CMD_CHECK, 1'b0, '0, '0, 8'd0, 8'd0);
        for (int i = 0; i < 6; i++)
            send_command(CMD_DELETE, 1'b0, '0, '0, 8'd0, 8'd0);
        drain_responses();
    endtask

    // Random mix; addresses drawn from a small pool so deletes and checks hit.
    task automatic test_random(input int count);
        logic [63:0] pool_hi [8];
        logic [63:0] pool_lo [8];
        int          k;
        logic [1:0]  cmd;
        for (int i = 0; i < 8; i++) begin
            pool_hi[i] = rand_word();
            pool_lo[i] = rand_word();
        end
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(7);
            case ($urandom_range(9))
                0, 1, 2, 3: cmd = CMD_PUSH;
                4, 5:       cmd = CMD_DELETE;
                9:          cmd = ($urandom_range(3) == 0) ? CMD_NONE : CMD_CHECK;
                default:    cmd = CMD_CHECK;
            endcase
            if ($urandom_range(3) == 0)
                send_command(cmd, 1'($urandom_range(1)), rand_word(), rand_word(),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
            else
                send_command(cmd, 1'($urandom_range(1)),
                             pool_hi[k] ^ ($urandom_range(1) ? 64'd0 : {$urandom, $urandom}),
                             pool_lo[k] ^ 64'($urandom_range(255)),
                             8'($urandom_range(140)), 8'($urandom_range(255)));
        end
        drain_responses();
    endtask

    // Hold the receiver off while commands pile up against the input.
    task automatic test_backpressure();
        send_idle_pct   = 0;
        hold_off_cycles = 400;
        test_random(40);
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_cmd           = CMD_NONE;
        s_is_v6         = 1'b0;
        s_addr_hi       = '0;
        s_addr_lo       = '0;
        s_prefix_len    = '0;
        s_action_code   = '0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        tbl_count       = 0;
        default_done    = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_full_table();
        test_random(300);
        send_idle_pct = 49;
        test_random(300);
        send_idle_pct  = 0;
        recv_stall_pct = 49;
        test_random(300);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        test_random(300);
        recv_stall_pct = 0;
        test_backpressure();

        drain_responses();
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
